// File: design/tga_rle_image_decoder_top_macros.svh
// Assertion macros shared by the TGA decoder RTL.
`ifndef TGA_RLE_IMAGE_DECODER_TOP_MACROS_SVH
`define TGA_RLE_IMAGE_DECODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TGA_RLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TGA_RLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/tga_rle_pkg.sv
// Types and constants of the TGA RLE image decoder.
`timescale 1ns / 1ps

package tga_rle_pkg;

  typedef enum logic [1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_HEADER    = 2'd1,
    KIND_BAD_TYPE  = 2'd2,
    KIND_BAD_DEPTH = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic [7:0]  repeat_res;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        last;
  } res_t;

  // header byte positions
  localparam logic [4:0] HDR_TYPE_IDX   = 5'd2;
  localparam logic [4:0] HDR_FIXED_LEN  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
  localparam logic [4:0] HDR_DEPTH_IDX  = 5'd16;

  localparam logic [7:0] TYPE_RAW       = 8'h02;
  localparam logic [7:0] TYPE_RLE       = 8'h0A;
  localparam logic [7:0] DEPTH_24       = 8'd24;
  localparam logic [7:0] DEPTH_32       = 8'd32;
  localparam logic [7:0] RUN_BIAS       = 8'd127;
  localparam logic [7:0] ALPHA_OPAQUE   = 8'd255;

  // last byte index within a pixel
  localparam logic [1:0] BIP_TOP_RGB    = 2'd2;
  localparam logic [1:0] BIP_TOP_RGBA   = 2'd3;

endpackage

// File: design/tga_rle_in_if.sv
// Byte input channel of the TGA decoder.
`timescale 1ns / 1ps

interface tga_rle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

// File: design/tga_rle_out_if.sv
// Result output channel of the TGA decoder.
`timescale 1ns / 1ps

interface tga_rle_out_if;
  logic                valid;
  logic                ready;
  tga_rle_pkg::kind_t  kind;
  logic [7:0]          blue;
  logic [7:0]          green;
  logic [7:0]          red;
  logic [7:0]          alpha;
  logic [7:0]          repeat_res;
  logic [15:0]         image_width;
  logic [15:0]         image_height;
  logic                last;

  modport source (output valid, output kind, output blue, output green, output red,
                  output alpha, output repeat_res, output image_width,
                  output image_height, output last, input ready);
  modport sink   (input valid, input kind, input blue, input green, input red,
                  input alpha, input repeat_res, input image_width,
                  input image_height, input last, output ready);
endinterface

// File: design/tga_rle_image_decoder_top.sv
// TGA decoder: one file byte per transfer; header verdict and BGRA pixel results.
// A result is registered into the output register, or into the skid entry while the output is stalled.
// One byte per cycle while the skid entry is empty; the parser state updates once per accepted byte.
// A two-entry output buffer keeps input transfers going while one result waits.
// Reset (rst, synchronous): parser waits for header byte 0, output buffer empties.
`timescale 1ns / 1ps
`include "tga_rle_image_decoder_top_macros.svh"

module tga_rle_image_decoder_top (
  input  logic                  clk,
  input  logic                  rst,
  tga_rle_in_if.sink            in_ch,
  tga_rle_out_if.source         out_ch
);

  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_HDR       = 8'b0000_0010,
    PH_HDR_TYPE  = 8'b0000_0100,
    PH_HDR_DEPTH = 8'b0000_1000,
    PH_RAW       = 8'b0001_0000,
    PH_PKT_HDR   = 8'b0010_0000,
    PH_PKT_LIT   = 8'b0100_0000,
    PH_PKT_RUN   = 8'b1000_0000
  } phase_t;

  phase_t      phase, phase_next, cur_phase;
  logic [4:0]  header_index, header_index_next, cur_idx;
  logic        is_rle, is_rle_next;
  logic        has_alpha, has_alpha_next;
  logic [15:0] width_store, width_store_next;
  logic [15:0] height_store, height_store_next;
  logic [31:0] pixels_left, pixels_left_next;
  logic [7:0]  packet_left, packet_left_next;
  logic [1:0]  byte_in_pixel, byte_in_pixel_next;
  logic [23:0] pixel_gather, pixel_gather_next;

  logic [31:0] area;
  logic [7:0]  b;
  logic [7:0]  run_len;
  logic        pix_done;
  logic [7:0]  pix_red, pix_alpha;
  logic        pix_last;

  tga_rle_pkg::res_t res;
  logic              res_valid;
  tga_rle_pkg::res_t out_data, skid_data;
  logic              out_valid, skid_valid;
  logic              accept;

  logic              pix_phase, rgb_gather, last_xfer, out_nonpix;

  assign accept    = in_ch.valid && in_ch.ready;
  assign b         = in_ch.data_byte;
  // a start flag restarts parsing at header byte 0
  assign cur_phase = in_ch.file_start ? PH_HDR : phase;
  assign cur_idx   = in_ch.file_start ? 5'd0 : header_index;
  assign area      = {16'd0, width_store} * {16'd0, height_store};

  assign pix_done  = byte_in_pixel == (has_alpha ? tga_rle_pkg::BIP_TOP_RGBA
                                                  : tga_rle_pkg::BIP_TOP_RGB);
  assign pix_red   = has_alpha ? pixel_gather[23:16] : b;
  assign pix_alpha = has_alpha ? b : tga_rle_pkg::ALPHA_OPAQUE;

  always_comb begin
    phase_next         = cur_phase;
    header_index_next  = cur_idx;
    is_rle_next        = is_rle;
    has_alpha_next     = has_alpha;
    width_store_next   = width_store;
    height_store_next  = height_store;
    pixels_left_next   = pixels_left;
    packet_left_next   = packet_left;
    byte_in_pixel_next = byte_in_pixel;
    pixel_gather_next  = pixel_gather;
    res                = '0;
    res_valid          = 1'b0;
    run_len            = '0;
    pix_last           = 1'b0;

    case (cur_phase)
      PH_HDR, PH_HDR_TYPE, PH_HDR_DEPTH: begin
        header_index_next = cur_idx + 5'd1;
        if (cur_idx < tga_rle_pkg::HDR_FIXED_LEN) begin
          if (cur_idx == tga_rle_pkg::HDR_TYPE_IDX) begin
            if (b == tga_rle_pkg::TYPE_RAW) begin
              is_rle_next = 1'b0;
            end else if (b == tga_rle_pkg::TYPE_RLE) begin
              is_rle_next = 1'b1;
            end else if (cur_phase == PH_HDR) begin
              phase_next = PH_HDR_TYPE;
            end
          end else if (b != 8'd0 && cur_phase == PH_HDR) begin
            phase_next = PH_HDR_TYPE;
          end
        end else if (cur_idx == tga_rle_pkg::HDR_WIDTH_LO) begin
          width_store_next = {width_store[15:8], b};
        end else if (cur_idx == tga_rle_pkg::HDR_WIDTH_HI) begin
          width_store_next = {b, width_store[7:0]};
        end else if (cur_idx == tga_rle_pkg::HDR_HEIGHT_LO) begin
          height_store_next = {height_store[15:8], b};
        end else if (cur_idx == tga_rle_pkg::HDR_HEIGHT_HI) begin
          height_store_next = {b, height_store[7:0]};
        end else if (cur_idx == tga_rle_pkg::HDR_DEPTH_IDX) begin
          has_alpha_next = b == tga_rle_pkg::DEPTH_32;
          if (b != tga_rle_pkg::DEPTH_24 && b != tga_rle_pkg::DEPTH_32 &&
              cur_phase == PH_HDR) begin
            phase_next = PH_HDR_DEPTH;
          end
        end else begin
          // final header byte: give the verdict
          header_index_next = '0;
          res_valid         = 1'b1;
          if (cur_phase == PH_HDR_TYPE) begin
            phase_next = PH_IDLE;
            res.kind   = tga_rle_pkg::KIND_BAD_TYPE;
          end else if (cur_phase == PH_HDR_DEPTH) begin
            phase_next = PH_IDLE;
            res.kind   = tga_rle_pkg::KIND_BAD_DEPTH;
          end else begin
            pixels_left_next   = area;
            byte_in_pixel_next = '0;
            pixel_gather_next  = '0;
            packet_left_next   = '0;
            res.kind           = tga_rle_pkg::KIND_HEADER;
            res.image_width    = width_store;
            res.image_height   = height_store;
            if (width_store == 16'd0 || height_store == 16'd0) begin
              phase_next = PH_IDLE;
              res.last   = 1'b1;
            end else begin
              phase_next = is_rle ? PH_PKT_HDR : PH_RAW;
            end
          end
        end
      end

      PH_RAW, PH_PKT_LIT, PH_PKT_RUN: begin
        if (!pix_done) begin
          byte_in_pixel_next = byte_in_pixel + 2'd1;
          case (byte_in_pixel)
            2'd0:    pixel_gather_next[7:0]   = b;
            2'd1:    pixel_gather_next[15:8]  = b;
            2'd2:    pixel_gather_next[23:16] = b;
            default: pixel_gather_next        = pixel_gather;
          endcase
        end else begin
          byte_in_pixel_next = '0;
          pixel_gather_next  = '0;
          res_valid          = 1'b1;
          res.kind           = tga_rle_pkg::KIND_PIXEL;
          res.blue           = pixel_gather[7:0];
          res.green          = pixel_gather[15:8];
          res.red            = pix_red;
          res.alpha          = pix_alpha;
          if (cur_phase == PH_PKT_RUN) begin
            pixels_left_next = pixels_left - {24'd0, packet_left};
            pix_last         = pixels_left == {24'd0, packet_left};
            packet_left_next = '0;
            res.repeat_res   = packet_left;
            phase_next       = PH_PKT_HDR;
          end else begin
            pixels_left_next = pixels_left - 32'd1;
            pix_last         = pixels_left == 32'd1;
            res.repeat_res   = 8'd1;
            if (cur_phase == PH_PKT_LIT) begin
              packet_left_next = packet_left - 8'd1;
              if (packet_left == 8'd1) begin
                phase_next = PH_PKT_HDR;
              end
            end
          end
          res.last = pix_last;
          if (pix_last) begin
            phase_next = PH_IDLE;
          end
        end
      end

      PH_PKT_HDR: begin
        run_len = b[7] ? (b - tga_rle_pkg::RUN_BIAS) : (b + 8'd1);
        // clamp packets that overrun the image end
        if ({24'd0, run_len} > pixels_left) begin
          run_len = pixels_left[7:0];
        end
        packet_left_next   = run_len;
        byte_in_pixel_next = '0;
        pixel_gather_next  = '0;
        phase_next         = b[7] ? PH_PKT_RUN : PH_PKT_LIT;
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR;
      header_index  <= '0;
      is_rle        <= 1'b0;
      has_alpha     <= 1'b0;
      width_store   <= '0;
      height_store  <= '0;
      pixels_left   <= '0;
      packet_left   <= '0;
      byte_in_pixel <= '0;
      pixel_gather  <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      header_index  <= header_index_next;
      is_rle        <= is_rle_next;
      has_alpha     <= has_alpha_next;
      width_store   <= width_store_next;
      height_store  <= height_store_next;
      pixels_left   <= pixels_left_next;
      packet_left   <= packet_left_next;
      byte_in_pixel <= byte_in_pixel_next;
      pixel_gather  <= pixel_gather_next;
    end
  end

  // output register plus skid entry
  assign in_ch.ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ch.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && res_valid;
      end
    end else if (accept && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ch.ready) begin
      out_data <= skid_valid ? skid_data : res;
    end else if (accept && res_valid) begin
      skid_data <= res;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.kind         = out_data.kind;
  assign out_ch.blue         = out_data.blue;
  assign out_ch.green        = out_data.green;
  assign out_ch.red          = out_data.red;
  assign out_ch.alpha        = out_data.alpha;
  assign out_ch.repeat_res   = out_data.repeat_res;
  assign out_ch.image_width  = out_data.image_width;
  assign out_ch.image_height = out_data.image_height;
  assign out_ch.last         = out_data.last;

  assign pix_phase  = phase inside {PH_RAW, PH_PKT_HDR, PH_PKT_LIT, PH_PKT_RUN};
  assign rgb_gather = (phase inside {PH_RAW, PH_PKT_LIT, PH_PKT_RUN}) && !has_alpha;
  assign last_xfer  = accept && res_valid && res.last;
  assign out_nonpix = out_valid && out_data.kind != tga_rle_pkg::KIND_PIXEL;

  `TGA_RLE_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid entry without output entry")
  `TGA_RLE_ASSERT_NOW(a_pix_left_nonzero, pix_phase, pixels_left != 32'd0, "no pixels left")
  `TGA_RLE_ASSERT_NOW(a_rgb_byte_count, rgb_gather, byte_in_pixel != 2'd3, "RGB pixel overrun")
  `TGA_RLE_ASSERT_NEXT(a_last_goes_idle, last_xfer, phase == PH_IDLE, "not idle after end")
  `TGA_RLE_ASSERT_NOW(a_repeat_on_pixel, out_nonpix, out_data.repeat_res == 8'd0, "bad repeat")

endmodule
